[rtl/csb_pkg.sv]
`timescale 1ns / 1ps
// Package for the clipped character sprite blitter.
// Holds geometry constants, opcodes, register indexes and the control structs.
package csb_pkg;

  localparam int SCREEN_W     = 256;
  localparam int SCREEN_H     = 32;
  localparam int NUM_SPRITES  = 16;
  localparam int SPRITE_MAX_W = 16;
  localparam int SPRITE_MAX_H = 16;

  localparam int SCR_XW    = $clog2(SCREEN_W);
  localparam int SCR_YW    = $clog2(SCREEN_H);
  localparam int SCR_AW    = SCR_XW + SCR_YW;
  localparam int SCR_CELLS = SCREEN_W * SCREEN_H;
  localparam int SPR_IW    = $clog2(NUM_SPRITES);
  localparam int SPR_CW    = $clog2(SPRITE_MAX_W);
  localparam int SPR_RW    = $clog2(SPRITE_MAX_H);
  localparam int PAT_AW    = SPR_IW + SPR_RW + SPR_CW;
  localparam int PAT_CELLS = NUM_SPRITES * SPRITE_MAX_H * SPRITE_MAX_W;

  localparam logic [7:0] SPACE_GLYPH = 8'h20;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_SIZE  = 3'd1;
  localparam logic [2:0] OP_DRAW  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y = 1'd1;

  typedef struct packed {
    logic capture;
    logic pat_write;
    logic size_write;
    logic scr_read;
    logic walk_step;
    logic clr_step;
    logic out_load;
  } csb_cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       draw_skip;
    logic       walk_last;
    logic       clr_last;
  } csb_sts_t;

endpackage

[rtl/csb_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the sprite blitter: valid, ready and the command fields.
// Depends on nothing else.
interface csb_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [3:0]         sprite_id;
  logic [4:0]         cell_row;
  logic [7:0]         cell_col;
  logic [7:0]         glyph;
  logic [4:0]         sprite_width;
  logic [4:0]         sprite_height;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, opcode, sprite_id, cell_row, cell_col, glyph,
                  sprite_width, sprite_height, pos_x, pos_y, input ready);
  modport sink (input valid, opcode, sprite_id, cell_row, cell_col, glyph,
                sprite_width, sprite_height, pos_x, pos_y, output ready);
endinterface

[rtl/csb_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel of the sprite blitter: valid, ready and the result fields.
// Depends on nothing else.
interface csb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_glyph;
  logic [2:0] done_opcode;

  modport source (output valid, read_glyph, done_opcode, input ready);
  modport sink (input valid, read_glyph, done_opcode, output ready);
endinterface

[rtl/csb_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the sprite blitter.
// Depends on csb_pkg for the opcodes and the command and status structs.
module csb_ctrl
  import csb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  csb_sts_t sts,
  output csb_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_INIT     = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_DISPATCH = 7'b0000100,
    S_DRAW     = 7'b0001000,
    S_DRAIN    = 7'b0010000,
    S_CLEAR    = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   slot_free;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.opcode)
          OP_LOAD: begin
            cmd.pat_write = 1'b1;
            state_next    = S_FINISH;
          end
          OP_SIZE: begin
            cmd.size_write = 1'b1;
            state_next     = S_FINISH;
          end
          OP_DRAW: begin
            state_next = sts.draw_skip ? S_FINISH : S_DRAW;
          end
          OP_READ: begin
            cmd.scr_read = 1'b1;
            state_next   = S_FINISH;
          end
          OP_CLEAR: begin
            state_next = S_CLEAR;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_DRAW: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.out_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten while full");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_DISPATCH))
    else $error("accepted transaction not dispatched");

  a_draw_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW && sts.walk_last) |=> (state == S_DRAIN))
    else $error("draw walk did not drain after its last cell");

  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && sts.clr_last) |=> (state == S_FINISH))
    else $error("clear sweep did not finish after its last cell");

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state register is not one-hot");

endmodule

[rtl/csb_dpath.sv]
`timescale 1ns / 1ps
// Datapath of the sprite blitter: camera registers, size table, pattern and
// screen memories, cell walk counters and the result register. Uses csb_pkg.
module csb_dpath
  import csb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  input  logic [2:0]           opcode,
  input  logic [3:0]           sprite_id,
  input  logic [4:0]           cell_row,
  input  logic [7:0]           cell_col,
  input  logic [7:0]           glyph,
  input  logic [4:0]           sprite_width,
  input  logic [4:0]           sprite_height,
  input  logic signed [15:0]   pos_x,
  input  logic signed [15:0]   pos_y,
  input  csb_cmd_t             cmd,
  output csb_sts_t             sts,
  output logic [7:0]           read_glyph,
  output logic [2:0]           done_opcode
);

  logic signed [15:0] cam_x, cam_y;

  logic [2:0]        op_r;
  logic [SPR_IW-1:0] id_r;
  logic [4:0]        row_r;
  logic [7:0]        col_r;
  logic [7:0]        glyph_r;
  logic [4:0]        sw_r, sh_r;
  logic signed [16:0] base_x, base_y;

  logic [4:0] size_w [NUM_SPRITES];
  logic [4:0] size_h [NUM_SPRITES];
  logic [4:0] cur_w, cur_h;

  logic [SPR_RW-1:0] walk_row;
  logic [SPR_CW-1:0] walk_col;
  logic              col_last, row_last;

  logic [SCR_AW-1:0] clr_addr;

  logic [7:0]        pat_mem [PAT_CELLS];
  logic [7:0]        pat_rdata;
  logic [7:0]        scr_mem [SCR_CELLS];
  logic [7:0]        scr_rdata;

  logic signed [17:0] sx, sy;
  logic               on_screen;
  logic               p_valid;
  logic [SCR_AW-1:0]  p_addr;

  logic              load_ok, read_ok;
  logic [SCR_AW-1:0] rd_addr;

  function automatic logic cell_ok_row(input logic [4:0] r);
    return r < 5'(SPRITE_MAX_H);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CAM_X) begin
        cam_x <= $signed(cfg_data);
      end
      if (cfg_index == CFG_CAM_Y) begin
        cam_y <= $signed(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= opcode;
      id_r    <= sprite_id[SPR_IW-1:0];
      row_r   <= cell_row;
      col_r   <= cell_col;
      glyph_r <= glyph;
      sw_r    <= (sprite_width > 5'(SPRITE_MAX_W)) ? 5'(SPRITE_MAX_W) : sprite_width;
      sh_r    <= (sprite_height > 5'(SPRITE_MAX_H)) ? 5'(SPRITE_MAX_H) : sprite_height;
      base_x  <= 17'(pos_x) - 17'(cam_x);
      base_y  <= 17'(pos_y) - 17'(cam_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SPRITES; k++) begin
        size_w[k] <= '0;
        size_h[k] <= '0;
      end
    end else if (cmd.size_write) begin
      size_w[id_r] <= sw_r;
      size_h[id_r] <= sh_r;
    end
  end

  assign cur_w    = size_w[id_r];
  assign cur_h    = size_h[id_r];
  assign col_last = ({1'b0, walk_col} == 5'(cur_w - 5'd1));
  assign row_last = ({1'b0, walk_row} == 5'(cur_h - 5'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_row <= '0;
      walk_col <= '0;
    end else if (cmd.walk_step) begin
      if (col_last) begin
        walk_col <= '0;
        walk_row <= row_last ? '0 : walk_row + 1'b1;
      end else begin
        walk_col <= walk_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sx        = 18'(base_x) + 18'(walk_col);
  assign sy        = 18'(base_y) + 18'(walk_row);
  assign on_screen = !sx[17] && (sx[16:0] < 17'(SCREEN_W)) &&
                     !sy[17] && (sy[16:0] < 17'(SCREEN_H));

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.walk_step && on_screen;
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= {sy[SCR_YW-1:0], sx[SCR_XW-1:0]};
  end

  assign load_ok = (cell_ok_row(row_r)) && (col_r < 8'(SPRITE_MAX_W));

  always_ff @(posedge clk) begin
    if (cmd.pat_write && load_ok) begin
      pat_mem[{id_r, row_r[SPR_RW-1:0], col_r[SPR_CW-1:0]}] <= glyph_r;
    end
    pat_rdata <= pat_mem[{id_r, walk_row, walk_col}];
  end

  assign rd_addr = {row_r[SCR_YW-1:0], col_r[SCR_XW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      scr_mem[clr_addr] <= SPACE_GLYPH;
    end else if (p_valid) begin
      scr_mem[p_addr] <= pat_rdata;
    end
    if (cmd.scr_read) begin
      scr_rdata <= scr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scr_read) begin
      read_ok <= (9'(row_r) < 9'(SCREEN_H)) && (9'(col_r) < 9'(SCREEN_W));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_glyph  <= (op_r == OP_READ && read_ok) ? scr_rdata : 8'd0;
      done_opcode <= op_r;
    end
  end

  assign sts.opcode    = op_r;
  assign sts.draw_skip = (cur_w == 5'd0) || (cur_h == 5'd0);
  assign sts.walk_last = col_last && row_last;
  assign sts.clr_last  = (clr_addr == SCR_AW'(SCR_CELLS - 1));

endmodule

[rtl/clipped_character_sprite_blit.sv]
`timescale 1ns / 1ps
// Clipped character sprite blitter, top level. Uses csb_pkg, csb_req_if, csb_rsp_if.
// Load, set size, read, zero-size draw and unused opcodes go from dispatch straight to finish.
// A draw walks the sprite at one sprite cell per cycle through the
// single pattern read port. A clear sweeps one screen cell per cycle.
// After reset the block sweeps the screen to spaces before taking requests.
module clipped_character_sprite_blit
  import csb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  csb_req_if.sink              req,
  csb_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  csb_cmd_t cmd;
  csb_sts_t sts;

  csb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csb_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (req.opcode),
    .sprite_id     (req.sprite_id),
    .cell_row      (req.cell_row),
    .cell_col      (req.cell_col),
    .glyph         (req.glyph),
    .sprite_width  (req.sprite_width),
    .sprite_height (req.sprite_height),
    .pos_x         (req.pos_x),
    .pos_y         (req.pos_y),
    .cmd           (cmd),
    .sts           (sts),
    .read_glyph    (rsp.read_glyph),
    .done_opcode   (rsp.done_opcode)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench for clipped_character_sprite_blit: directed and random tests with an in-bench predictor
// of the pattern store, size table, screen and camera. Depends on csb_pkg, csb_req_if, csb_rsp_if.
module testbench;
  import csb_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam longint TIMEOUT_NS = 64'd60_000_000;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         sprite_id;
    logic [4:0]         cell_row;
    logic [7:0]         cell_col;
    logic [7:0]         glyph;
    logic [4:0]         sprite_width;
    logic [4:0]         sprite_height;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } blit_cmd_t;

  typedef struct packed {
    logic [7:0] read_glyph;
    logic [2:0] done_opcode;
  } blit_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  csb_req_if req_ch ();
  csb_rsp_if rsp_ch ();

  clipped_character_sprite_blit DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [7:0] pattern_mem [PAT_CELLS];
  bit pattern_known [PAT_CELLS];
  logic [4:0] size_w [NUM_SPRITES];
  logic [4:0] size_h [NUM_SPRITES];
  logic [7:0] screen_mem [SCR_CELLS];
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;

  blit_result_t pending_results [$];
  int error_count = 0;
  int sent_items = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pat_index(input logic [3:0] id, input int row, input int col);
    return (int'(id) * SPRITE_MAX_H + row) * SPRITE_MAX_W + col;
  endfunction

  function automatic blit_result_t predict_blit(input blit_cmd_t c);
    blit_result_t r;
    int i;
    int j;
    int sx;
    int sy;
    int k;
    r.read_glyph = 8'h00;
    r.done_opcode = c.opcode;
    case (c.opcode)
      OP_LOAD: begin
        if (c.sprite_id < NUM_SPRITES && c.cell_row < SPRITE_MAX_H &&
            c.cell_col < SPRITE_MAX_W) begin
          k = pat_index(c.sprite_id, int'(c.cell_row), int'(c.cell_col));
          pattern_mem[k] = c.glyph;
          pattern_known[k] = 1'b1;
        end
      end
      OP_SIZE: begin
        if (c.sprite_id < NUM_SPRITES) begin
          size_w[c.sprite_id] = (c.sprite_width > SPRITE_MAX_W) ?
                                5'(SPRITE_MAX_W) : c.sprite_width;
          size_h[c.sprite_id] = (c.sprite_height > SPRITE_MAX_H) ?
                                5'(SPRITE_MAX_H) : c.sprite_height;
        end
      end
      OP_DRAW: begin
        if (c.sprite_id < NUM_SPRITES) begin
          for (i = 0; i < int'(size_h[c.sprite_id]); i++) begin
            sy = int'(c.pos_y) + i - int'(view_y);
            if (sy < 0 || sy >= SCREEN_H) continue;
            for (j = 0; j < int'(size_w[c.sprite_id]); j++) begin
              sx = int'(c.pos_x) + j - int'(view_x);
              if (sx < 0 || sx >= SCREEN_W) continue;
              screen_mem[sy * SCREEN_W + sx] = pattern_mem[pat_index(c.sprite_id, i, j)];
            end
          end
        end
      end
      OP_READ: begin
        if (c.cell_row < SCREEN_H && c.cell_col < SCREEN_W)
          r.read_glyph = screen_mem[int'(c.cell_row) * SCREEN_W + int'(c.cell_col)];
      end
      OP_CLEAR: begin
        for (k = 0; k < SCR_CELLS; k++) screen_mem[k] = SPACE_GLYPH;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic blit_cmd_t rand_cmd(input logic [2:0] op);
    blit_cmd_t c;
    c.opcode = op;
    c.sprite_id = 4'($urandom_range(15));
    c.cell_row = 5'($urandom_range(31));
    c.cell_col = 8'($urandom_range(255));
    c.glyph = 8'($urandom_range(255));
    c.sprite_width = 5'($urandom_range(31));
    c.sprite_height = 5'($urandom_range(31));
    c.pos_x = 16'($urandom_range(65535));
    c.pos_y = 16'($urandom_range(65535));
    return c;
  endfunction

  always @(posedge clk) begin : check_results
    blit_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual glyph %h opcode %0d",
                 $time, rsp_ch.read_glyph, rsp_ch.done_opcode);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.read_glyph !== want.read_glyph) begin
          $display("%0t: read_glyph mismatch: expected %h, actual %h",
                   $time, want.read_glyph, rsp_ch.read_glyph);
          error_count++;
        end
        if (rsp_ch.done_opcode !== want.done_opcode) begin
          $display("%0t: done_opcode mismatch: expected %0d, actual %0d",
                   $time, want.done_opcode, rsp_ch.done_opcode);
          error_count++;
        end
      end
    end
    rsp_ch.ready <= (rcv_stall_pct == 0) || ($urandom_range(99) >= rcv_stall_pct);
  end

  task automatic send_cmd(input blit_cmd_t c);
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= c.opcode;
    req_ch.sprite_id <= c.sprite_id;
    req_ch.cell_row <= c.cell_row;
    req_ch.cell_col <= c.cell_col;
    req_ch.glyph <= c.glyph;
    req_ch.sprite_width <= c.sprite_width;
    req_ch.sprite_height <= c.sprite_height;
    req_ch.pos_x <= c.pos_x;
    req_ch.pos_y <= c.pos_y;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_blit(c));
    sent_items++;
  endtask

  task automatic wait_all_done();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_camera(input logic signed [15:0] x, input logic signed [15:0] y);
    wait_all_done();
    cfg_we <= 1'b1;
    cfg_index <= CFG_CAM_X;
    cfg_data <= x;
    @(posedge clk);
    cfg_index <= CFG_CAM_Y;
    cfg_data <= y;
    @(posedge clk);
    cfg_we <= 1'b0;
    view_x = x;
    view_y = y;
  endtask

  task automatic send_read(input int row, input int col);
    blit_cmd_t c;
    c = rand_cmd(OP_READ);
    c.cell_row = row[4:0];
    c.cell_col = col[7:0];
    send_cmd(c);
  endtask

  task automatic send_load(input logic [3:0] id, input int row, input int col,
                           input logic [7:0] g);
    blit_cmd_t c;
    c = rand_cmd(OP_LOAD);
    c.sprite_id = id;
    c.cell_row = row[4:0];
    c.cell_col = col[7:0];
    c.glyph = g;
    send_cmd(c);
  endtask

  task automatic send_size(input logic [3:0] id, input int w, input int h);
    blit_cmd_t c;
    c = rand_cmd(OP_SIZE);
    c.sprite_id = id;
    c.sprite_width = w[4:0];
    c.sprite_height = h[4:0];
    send_cmd(c);
  endtask

  task automatic send_draw(input logic [3:0] id, input int x, input int y);
    blit_cmd_t c;
    c = rand_cmd(OP_DRAW);
    c.sprite_id = id;
    c.pos_x = x[15:0];
    c.pos_y = y[15:0];
    send_cmd(c);
  endtask

  task automatic check_power_up_screen();
    send_read(0, 0);
    send_read(SCREEN_H - 1, SCREEN_W - 1);
  endtask

  task automatic check_clipped_draws();
    send_size(4'd1, 2, 2);
    send_load(4'd1, 0, 0, 8'h00);
    send_load(4'd1, 0, 1, 8'hFF);
    send_load(4'd1, 1, 0, 8'hAA);
    send_load(4'd1, 1, 1, 8'h55);
    send_load(4'd1, 16, 0, 8'h11);
    send_load(4'd1, 31, 255, 8'h22);
    send_draw(4'd1, 0, 0);
    send_read(0, 0);
    send_read(1, 1);
    send_draw(4'd1, -1, -1);
    send_read(0, 0);
    send_draw(4'd1, SCREEN_W - 1, SCREEN_H - 1);
    send_read(SCREEN_H - 1, SCREEN_W - 1);
    send_draw(4'd1, 32767, -32768);
  endtask

  task automatic check_size_limits();
    send_size(4'd15, 31, 17);
    send_size(4'd3, 0, 0);
    send_draw(4'd3, 0, 0);
  endtask

  task automatic check_spare_opcodes_and_clear();
    send_cmd(rand_cmd(OP_SPARE_LO));
    send_cmd(rand_cmd(OP_SPARE_HI));
    send_cmd(rand_cmd(OP_CLEAR));
    send_read(0, 0);
  endtask

  // Size a sprite, fill every cell it covers, then draw it around the camera window and
  // read back cells in and just beside the drawn area, with some noise items mixed in.
  task automatic run_sprite_burst();
    logic [3:0] id;
    int w;
    int h;
    int ew;
    int eh;
    int i;
    int j;
    int n;
    int roll;
    int sx0;
    int sy0;
    roll = $urandom_range(99);
    id = 4'($urandom_range(NUM_SPRITES - 1));
    if (roll < 70) begin
      w = $urandom_range(6);
      h = $urandom_range(6);
    end else if (roll < 82) begin
      w = $urandom_range(SPRITE_MAX_W);
      h = $urandom_range(3);
    end else if (roll < 94) begin
      w = $urandom_range(3);
      h = $urandom_range(SPRITE_MAX_H);
    end else if (roll < 97) begin
      w = $urandom_range(31, 17);
      h = $urandom_range(2);
    end else begin
      w = $urandom_range(31);
      h = $urandom_range(31);
    end
    send_size(id, w, h);
    ew = int'(size_w[id]);
    eh = int'(size_h[id]);
    for (i = 0; i < eh; i++)
      for (j = 0; j < ew; j++)
        if (!pattern_known[pat_index(id, i, j)] || $urandom_range(99) < 30)
          send_load(id, i, j, 8'($urandom_range(255)));
    if ($urandom_range(99) < 20) begin
      if ($urandom_range(1))
        send_load(id, $urandom_range(31, SPRITE_MAX_H), $urandom_range(255),
                  8'($urandom_range(255)));
      else
        send_load(id, $urandom_range(31), $urandom_range(255, SPRITE_MAX_W),
                  8'($urandom_range(255)));
    end
    n = $urandom_range(3, 1);
    repeat (n) begin
      if ($urandom_range(99) < 10) begin
        send_draw(id, $urandom_range(65535), $urandom_range(65535));
      end else begin
        sx0 = $urandom_range(SCREEN_W + ew + 1) - ew - 1;
        sy0 = $urandom_range(SCREEN_H + eh + 1) - eh - 1;
        send_draw(id, int'(view_x) + sx0, int'(view_y) + sy0);
        repeat ($urandom_range(3, 1))
          send_read(sy0 + $urandom_range(eh), sx0 + $urandom_range(ew));
      end
    end
    roll = $urandom_range(99);
    if (roll < 5) send_cmd(rand_cmd(OP_CLEAR));
    else if (roll < 13) send_cmd(rand_cmd(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO))));
    else if (roll < 25) send_read($urandom_range(31), $urandom_range(255));
    else if (roll < 28) wait_all_done();
  endtask

  task automatic check_random_phases();
    int p;
    int target;
    logic signed [15:0] cam_list_x [PHASES];
    logic signed [15:0] cam_list_y [PHASES];
    cam_list_x = '{16'sd0, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                   16'sd0, 16'sd0, 16'sd0};
    cam_list_y = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                   16'sd0, 16'sd0, 16'sd0};
    cam_list_x[5] = 16'($urandom_range(80) - 40);
    cam_list_y[5] = 16'($urandom_range(80) - 40);
    cam_list_x[6] = 16'($urandom_range(65535));
    cam_list_y[6] = 16'($urandom_range(65535));
    cam_list_x[7] = 16'($urandom_range(600) - 300);
    cam_list_y[7] = 16'($urandom_range(100) - 50);
    for (p = 0; p < PHASES; p++) begin
      write_camera(cam_list_x[p], cam_list_y[p]);
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 74; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 74; end
        default: begin snd_idle_pct = 16; rcv_stall_pct = 16; end
      endcase
      target = sent_items + RANDOM_ITEMS / PHASES;
      while (sent_items < target) run_sprite_burst();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_LOAD;
    req_ch.sprite_id = '0;
    req_ch.cell_row = '0;
    req_ch.cell_col = '0;
    req_ch.glyph = '0;
    req_ch.sprite_width = '0;
    req_ch.sprite_height = '0;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    rsp_ch.ready = 1'b0;
    view_x = '0;
    view_y = '0;
    foreach (pattern_mem[k]) begin
      pattern_mem[k] = 8'h00;
      pattern_known[k] = 1'b0;
    end
    foreach (size_w[k]) begin
      size_w[k] = '0;
      size_h[k] = '0;
    end
    foreach (screen_mem[k]) screen_mem[k] = SPACE_GLYPH;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    check_power_up_screen();
    check_clipped_draws();
    check_size_limits();
    check_spare_opcodes_and_clear();
    check_random_phases();
    wait_all_done();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
